/* hw/rtl/spm_pkg.sv */
// Shared types, constants and shift helpers for the SPI master port.
package spm_pkg;

  localparam int FRAME_BITS = 8;
  localparam int BITS_W     = $clog2(FRAME_BITS + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_POLARITY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_PHASE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAUD_SELECT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LSB_FIRST      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_ENABLE    = 3'd4;

  localparam logic [2:0] BAUD_RESET = 3'd5;

  typedef enum logic [1:0] {
    ACT_TICK       = 2'd0,
    ACT_WRITE_DATA = 2'd1,
    ACT_READ_STAT  = 2'd2,
    ACT_READ_DATA  = 2'd3
  } action_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] write_byte;
    logic       miso_level;
  } spm_in_t;

  typedef struct packed {
    logic       sclk_level;
    logic       mosi_level;
    logic [7:0] read_byte;
    logic       rx_not_empty;
    logic       tx_empty;
    logic       busy_flag;
  } spm_out_t;

  typedef struct packed {
    logic       clock_polarity;
    logic       clock_phase;
    logic [2:0] baud_select;
    logic       lsb_first;
    logic       port_enable;
  } spm_cfg_t;

  function automatic logic [FRAME_BITS-1:0] shift_out(input logic [FRAME_BITS-1:0] v,
                                                       input logic lsb);
    if (lsb) begin
      return {1'b0, v[FRAME_BITS-1:1]};
    end
    return {v[FRAME_BITS-2:0], 1'b0};
  endfunction

  function automatic logic [FRAME_BITS-1:0] sample_in(input logic [FRAME_BITS-1:0] v,
                                                       input logic miso,
                                                       input logic lsb);
    if (lsb) begin
      return {miso, v[FRAME_BITS-1:1]};
    end
    return {v[FRAME_BITS-2:0], miso};
  endfunction

endpackage

/* hw/rtl/spi_master_port_unit.sv */
// Top level of the SPI master port.
// SPI master with one-byte transmit and receive buffers. Every item (tick, data write,
// status read, data read) is worked out when accepted and its result is registered in
// the output register; with the output side not stalling, one item is accepted every
// cycle. The state update and the result are formed in a single pass of logic ahead of
// the result register, which also lets a new item in while the previous result is being
// taken. Configuration is written through the plain write port; the user must write it
// only while no item is in flight (unenforced); indexes past the five defined are ignored.
module spi_master_port_unit import spm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  spm_in_t               in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output spm_out_t              out_item_o
);

  spm_cfg_t cfg;
  spm_out_t result;
  logic     accept;

  assign accept = in_valid_i && !in_stall_o;

  spm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  spm_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (accept),
    .item_i   (in_item_i),
    .result_o (result)
  );

  spm_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .result_i    (result),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* hw/rtl/spm_cfg_regs.sv */
// Configuration registers of the SPI master port.
module spm_cfg_regs import spm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output spm_cfg_t              cfg_o
);

  spm_cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CLOCK_POLARITY: cfg_d.clock_polarity = cfg_data_i[0];
        REG_CLOCK_PHASE:    cfg_d.clock_phase    = cfg_data_i[0];
        REG_BAUD_SELECT:    cfg_d.baud_select    = cfg_data_i[2:0];
        REG_LSB_FIRST:      cfg_d.lsb_first      = cfg_data_i[0];
        REG_PORT_ENABLE:    cfg_d.port_enable    = cfg_data_i[0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{clock_polarity: 1'b0, clock_phase: 1'b0, baud_select: BAUD_RESET,
                 lsb_first: 1'b0, port_enable: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/spm_core.sv */
// Shifter, prescaler and holding buffers; works out one item and its result.
module spm_core import spm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  spm_cfg_t cfg_i,
  input  logic     accept_i,
  input  spm_in_t  item_i,
  output spm_out_t result_o
);

  logic [7:0]            tx_hold_d, tx_hold_q;
  logic                  tx_full_d, tx_full_q;
  logic [FRAME_BITS-1:0] out_sh_d, out_sh_q;
  logic [FRAME_BITS-1:0] in_sh_d, in_sh_q;
  logic [7:0]            rx_hold_d, rx_hold_q;
  logic                  rx_full_d, rx_full_q;
  logic [BITS_W-1:0]     bits_d, bits_q;
  logic [7:0]            presc_d, presc_q;
  logic                  active_d, active_q;

  logic [7:0] presc_inc;
  logic [7:0] half_period;
  logic [7:0] rbyte;

  assign presc_inc   = presc_q + 8'd1;
  assign half_period = 8'd1 << cfg_i.baud_select;

  always_comb begin
    tx_hold_d = tx_hold_q;
    tx_full_d = tx_full_q;
    out_sh_d  = out_sh_q;
    in_sh_d   = in_sh_q;
    rx_hold_d = rx_hold_q;
    rx_full_d = rx_full_q;
    bits_d    = bits_q;
    presc_d   = presc_q;
    active_d  = active_q;
    rbyte     = 8'd0;
    case (item_i.action)
      ACT_TICK: begin
        if (!cfg_i.port_enable) begin
          bits_d   = '0;
          active_d = 1'b0;
          presc_d  = 8'd0;
        end else if (bits_q == '0) begin
          // load tick only: prescaler starts on the next one
          if (tx_full_q) begin
            out_sh_d  = tx_hold_q;
            in_sh_d   = '0;
            tx_full_d = 1'b0;
            bits_d    = BITS_W'(FRAME_BITS);
            presc_d   = 8'd0;
            active_d  = 1'b0;
          end
        end else if (presc_inc < half_period) begin
          presc_d = presc_inc;
        end else begin
          presc_d = 8'd0;
          if (!active_q) begin
            active_d = 1'b1;
            if (!cfg_i.clock_phase) begin
              in_sh_d = sample_in(in_sh_q, item_i.miso_level, cfg_i.lsb_first);
            end else if (bits_q < BITS_W'(FRAME_BITS)) begin
              out_sh_d = shift_out(out_sh_q, cfg_i.lsb_first);
            end
          end else begin
            active_d = 1'b0;
            bits_d   = bits_q - BITS_W'(1);
            if (cfg_i.clock_phase) begin
              in_sh_d = sample_in(in_sh_q, item_i.miso_level, cfg_i.lsb_first);
            end else if (bits_d != '0) begin
              out_sh_d = shift_out(out_sh_q, cfg_i.lsb_first);
            end
            if (bits_d == '0) begin
              rx_hold_d = in_sh_d[7:0];
              rx_full_d = 1'b1;
            end
          end
        end
      end
      ACT_WRITE_DATA: begin
        tx_hold_d = item_i.write_byte;
        tx_full_d = 1'b1;
      end
      ACT_READ_DATA: begin
        rbyte     = rx_hold_q;
        rx_full_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result_o.sclk_level   = cfg_i.clock_polarity ^ active_d;
    result_o.mosi_level   = cfg_i.lsb_first ? out_sh_d[0] : out_sh_d[FRAME_BITS-1];
    result_o.read_byte    = rbyte;
    result_o.rx_not_empty = rx_full_d;
    result_o.tx_empty     = !tx_full_d;
    result_o.busy_flag    = (bits_d != '0) || tx_full_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_hold_q <= '0;
      tx_full_q <= 1'b0;
      out_sh_q  <= '0;
      in_sh_q   <= '0;
      rx_hold_q <= '0;
      rx_full_q <= 1'b0;
      bits_q    <= '0;
      presc_q   <= '0;
      active_q  <= 1'b0;
    end else if (accept_i) begin
      tx_hold_q <= tx_hold_d;
      tx_full_q <= tx_full_d;
      out_sh_q  <= out_sh_d;
      in_sh_q   <= in_sh_d;
      rx_hold_q <= rx_hold_d;
      rx_full_q <= rx_full_d;
      bits_q    <= bits_d;
      presc_q   <= presc_d;
      active_q  <= active_d;
    end
  end

endmodule

/* hw/rtl/spm_out_reg.sv */
// Result register between the core and the output channel.
module spm_out_reg import spm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  spm_out_t result_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output spm_out_t out_item_o
);

  logic     valid_d, valid_q;
  spm_out_t item_q;
  logic     load;

  // a held item that is being taken frees the slot in the same cycle
  assign in_stall_o = valid_q && out_stall_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule
